// File: sv/lfsa_pkg.sv
`timescale 1ns / 1ps

package lfsa_pkg;

  // Table geometry.
  localparam int SLOT_COUNT  = 1024;
  localparam int HANDLE_BITS = 32;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int HINT_W      = SLOT_W + 1;

  // The occupancy bitmap is kept as rows of 64 bits.
  localparam int ROW_BITS  = 64;
  localparam int ROW_LSB   = $clog2(ROW_BITS);
  localparam int ROW_COUNT = (SLOT_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int LAST_ROW  = ROW_COUNT - 1;
  localparam int LAST_ROW_SLOTS = SLOT_COUNT - LAST_ROW * ROW_BITS;

  typedef logic [ROW_BITS-1:0]    row_t;
  typedef logic [HANDLE_BITS-1:0] store_handle_t;

  // Slots of the last row that exist.
  localparam row_t LAST_ROW_MASK = (LAST_ROW_SLOTS == ROW_BITS) ? '1 :
                                   row_t'((65'(1) << LAST_ROW_SLOTS) - 65'(1));

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_REGISTER = 2'd1,
    REQ_FREE     = 2'd2,
    REQ_LOOKUP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOD,
    S_LOOK
  } state_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } occ_rd_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    row_t             data;
  } occ_wr_t;

  // Index of the lowest set bit, found by halving the word six times.
  function automatic logic [ROW_LSB-1:0] lowest_set(input row_t v);
    row_t             w;
    logic [ROW_LSB-1:0] idx;
    w   = v;
    idx = '0;
    for (int k = ROW_LSB - 1; k >= 0; k--) begin
      if ((w & row_t'((65'(1) << (1 << k)) - 65'(1))) == '0) begin
        idx[k] = 1'b1;
        w      = w >> (1 << k);
      end
    end
    return idx;
  endfunction

  function automatic store_handle_t to_store(input logic [31:0] h);
    logic [63:0] w;
    w = 64'(h);
    return w[HANDLE_BITS-1:0];
  endfunction

  function automatic logic [31:0] from_store(input store_handle_t s);
    logic [63:0] w;
    w = 64'(s);
    return w[31:0];
  endfunction

endpackage

// File: sv/lfsa_occ_map.sv
`timescale 1ns / 1ps

// Occupancy bitmap in rows, with one valid bit per row so that reset
// empties the whole table at once.
module lfsa_occ_map (
  input  logic             clk,
  input  logic             rst,
  input  lfsa_pkg::occ_rd_t rd,
  input  lfsa_pkg::occ_wr_t wr,
  output lfsa_pkg::row_t    rd_data
);
  import lfsa_pkg::*;

  row_t                 mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] row_valid;
  row_t                 mem_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    if (rd.en) begin
      mem_q <= mem[rd.row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.row] <= 1'b1;
      end
      if (rd.en) begin
        valid_q <= row_valid[rd.row];
      end
    end
  end

  // A row never written since reset reads as all empty.
  assign rd_data = valid_q ? mem_q : '0;

endmodule

// File: sv/lowest_free_slot_id_allocator.sv
`timescale 1ns / 1ps

// Channel   Handshake            Word
// request   start / busy         req_type, slot_id, handle
// result    done (one cycle)     result_slot, result_handle, found, status
//
// A request is taken at a rising edge with start high and busy low. The
// result shows on the result ports for exactly one cycle with done high.
// Allocate scans the occupancy bitmap one 64-bit row per cycle through the
// find-first-free unit; a full table, or a hint at the top, answers without
// a scan, and any out-of-range slot answers without a bitmap read.
// Synchronous reset empties the table at once (a valid bit per bitmap row)
// and sets the hint to zero; no clearing pass is needed.
// The receiver cannot stall; a new request may be taken in the cycle that
// shows the previous result.
module lowest_free_slot_id_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [9:0]  slot_id,
  input  logic [31:0] handle,
  output logic        done,
  output logic [9:0]  result_slot,
  output logic [31:0] result_handle,
  output logic        found,
  output logic [1:0]  status
);
  import lfsa_pkg::*;

  state_t state, state_next;

  // Request held for the later cycles of a command.
  req_t                req_q;
  logic [9:0]          slot_q;
  logic [HINT_W-1:0]   start_q;

  // The next-free hint; SLOT_COUNT means no free slot is known.
  logic [HINT_W-1:0]   hint, hint_next;

  // Scan pointers: rd_row is the next row to fetch, chk_row the row whose
  // data is on the bitmap read port this cycle.
  logic [ROW_W:0]      rd_row, rd_row_next;
  logic [ROW_W-1:0]    chk_row, chk_row_next;

  // Handle store; a stored handle is only reported while its slot is occupied.
  store_handle_t       hmem [SLOT_COUNT];
  store_handle_t       hrd_q;

  occ_rd_t             occ_rd;
  occ_wr_t             occ_wr;
  row_t                occ_data;

  logic                accept;
  req_t                req_in;
  logic [SLOT_W-1:0]   slot_idx;
  logic                in_range;
  logic [HINT_W-1:0]   start_in;

  logic [SLOT_W-1:0]   slot_q_idx;
  row_t                slot_bit;
  row_t                above_mask;
  row_t                free_bits;

  logic                fin;
  logic [9:0]          fin_slot;
  logic [31:0]         fin_handle;
  logic                fin_found;
  status_t             fin_status;

  lfsa_occ_map u_occ (
    .clk     (clk),
    .rst     (rst),
    .rd      (occ_rd),
    .wr      (occ_wr),
    .rd_data (occ_data)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign req_in   = req_t'(req_type);
  assign slot_idx = SLOT_W'(slot_id);
  assign in_range = (32'(slot_id) < 32'(SLOT_COUNT));
  assign start_in = hint + HINT_W'(1);

  assign slot_q_idx = SLOT_W'(slot_q);
  assign slot_bit   = row_t'(1) << slot_q_idx[ROW_LSB-1:0];

  // Allocate looks only at slots strictly above the hint that was handed out.
  assign above_mask = ~((row_t'(1) << start_q[ROW_LSB-1:0]) - row_t'(1));

  always_comb begin
    free_bits = ~occ_data;
    if (chk_row == start_q[SLOT_W-1:ROW_LSB]) begin
      free_bits = free_bits & above_mask;
    end
    if (chk_row == ROW_W'(LAST_ROW)) begin
      free_bits = free_bits & LAST_ROW_MASK;
    end
  end

  always_comb begin
    state_next   = state;
    hint_next    = hint;
    rd_row_next  = rd_row;
    chk_row_next = chk_row;
    occ_rd       = '0;
    occ_wr       = '0;
    fin          = 1'b0;
    fin_slot     = slot_q;
    fin_handle   = '0;
    fin_found    = 1'b0;
    fin_status   = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          fin_slot = slot_id;
          if (req_in == REQ_ALLOC) begin
            if (hint >= HINT_W'(SLOT_COUNT)) begin
              // Nothing free is known: no id is handed out.
              fin        = 1'b1;
              fin_slot   = '0;
              fin_status = ST_FULL;
            end else if (start_in >= HINT_W'(SLOT_COUNT)) begin
              // The hint was the top slot, so there is nothing above to scan.
              fin        = 1'b1;
              fin_slot   = 10'(hint);
              fin_status = ST_FULL;
              hint_next  = HINT_W'(SLOT_COUNT);
            end else begin
              occ_rd.en    = 1'b1;
              occ_rd.row   = start_in[SLOT_W-1:ROW_LSB];
              chk_row_next = start_in[SLOT_W-1:ROW_LSB];
              rd_row_next  = (ROW_W+1)'(start_in[SLOT_W-1:ROW_LSB]) + (ROW_W+1)'(1);
              state_next   = S_SCAN;
            end
          end else if (!in_range) begin
            fin        = 1'b1;
            fin_status = ST_RANGE;
          end else begin
            // Fetch the bitmap row that holds the slot.
            occ_rd.en  = 1'b1;
            occ_rd.row = slot_idx[SLOT_W-1:ROW_LSB];
            state_next = (req_in == REQ_LOOKUP) ? S_LOOK : S_MOD;
          end
        end
      end

      S_SCAN: begin
        // Keep fetching one row a cycle while the current row is checked.
        if (rd_row <= (ROW_W+1)'(LAST_ROW)) begin
          occ_rd.en  = 1'b1;
          occ_rd.row = rd_row[ROW_W-1:0];
        end
        rd_row_next  = rd_row + (ROW_W+1)'(1);
        chk_row_next = chk_row + ROW_W'(1);
        if (free_bits != '0) begin
          fin        = 1'b1;
          fin_slot   = 10'(hint);
          hint_next  = HINT_W'({chk_row, lowest_set(free_bits)});
          state_next = S_IDLE;
        end else if (chk_row == ROW_W'(LAST_ROW)) begin
          fin        = 1'b1;
          fin_slot   = 10'(hint);
          fin_status = ST_FULL;
          hint_next  = HINT_W'(SLOT_COUNT);
          state_next = S_IDLE;
        end
      end

      S_MOD: begin
        occ_wr.en  = 1'b1;
        occ_wr.row = slot_q_idx[SLOT_W-1:ROW_LSB];
        if (req_q == REQ_REGISTER) begin
          occ_wr.data = occ_data | slot_bit;
          if (HINT_W'(slot_q_idx) == hint) begin
            hint_next = HINT_W'(slot_q_idx) + HINT_W'(1);
          end
        end else begin
          // Freeing an empty slot still lowers the hint.
          occ_wr.data = occ_data & ~slot_bit;
          if (HINT_W'(slot_q_idx) < hint) begin
            hint_next = HINT_W'(slot_q_idx);
          end
        end
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      S_LOOK: begin
        fin_found = |(occ_data & slot_bit);
        if (fin_found) begin
          fin_handle = from_store(hrd_q);
        end
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hint  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      hint  <= hint_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    rd_row  <= rd_row_next;
    chk_row <= chk_row_next;
    if (accept) begin
      req_q   <= req_in;
      slot_q  <= slot_id;
      start_q <= start_in;
    end
    if (fin) begin
      result_slot   <= fin_slot;
      result_handle <= fin_handle;
      found         <= fin_found;
      status        <= fin_status;
    end
  end

  // The handle is written and read in the acceptance cycle, together with the
  // bitmap row read; the bitmap write follows in the modify step.
  always_ff @(posedge clk) begin
    if (accept && in_range && (req_in == REQ_REGISTER)) begin
      hmem[slot_idx] <= to_store(handle);
    end
    if (accept && in_range && (req_in == REQ_LOOKUP)) begin
      hrd_q <= hmem[slot_idx];
    end
  end

  // The hint never points past the table.
  assert property (@(posedge clk) disable iff (rst) hint <= HINT_W'(SLOT_COUNT))
    else $error("next-free hint beyond table size");

  // A result only appears once the sequencer is back at rest.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is still in progress");

  // An accepted request either answers at once or keeps the block busy.
  assert property (@(posedge clk) disable iff (rst) accept |=> (busy || done))
    else $error("accepted request was dropped");

  // The bitmap is only written in the modify step.
  assert property (@(posedge clk) disable iff (rst) occ_wr.en |-> (state == S_MOD))
    else $error("bitmap written outside the modify step");

  // A hit is only ever reported as a good lookup.
  assert property (@(posedge clk) disable iff (rst)
                   (done && found) |-> (status == ST_OK))
    else $error("found flag with a failing status");

endmodule

// File: sim/lowest_free_slot_id_allocator_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the slot id allocator. Requests are planned up front
// in an initial block. A clocked driver hands them to the block one word at a
// time, and a clocked monitor compares every result word against the answer
// predicted when its request was taken.
module lowest_free_slot_id_allocator_test;
  import lfsa_pkg::*;

  // How the driver picks the word it sends. Most picks are settled only when
  // the word is about to go out, so that they can follow the table as it is
  // at that moment: the id just handed out, a slot that is in use, and so on.
  typedef enum logic [3:0] {
    PICK_FIXED,      // send the request exactly as planned
    PICK_ALLOC,
    PICK_REG_LAST,   // register the id that the last allocate handed out
    PICK_REG_HINT,   // register the slot the hint points at
    PICK_REG_ANY,
    PICK_FREE_USED,  // free a slot that is in use
    PICK_FREE_ANY,
    PICK_LOOK_USED,  // look up a slot that is in use
    PICK_LOOK_ANY,
    PICK_FILL,       // register the lowest empty slot, dropped when none is left
    PICK_DRAIN       // hold off until every result has come back
  } pick_t;

  typedef struct {
    pick_t             pick;
    req_t              op;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       handle;
    int unsigned       gap;     // idle cycles before this word goes out
  } plan_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [31:0]       handle;
    logic              found;
    status_t           status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = REQ_ALLOC;
  logic [9:0]  slot_id = '0;
  logic [31:0] handle = '0;
  logic        busy;
  logic        done;
  logic [9:0]  result_slot;
  logic [31:0] result_handle;
  logic        found;
  logic [1:0]  status;

  lowest_free_slot_id_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .slot_id       (slot_id),
    .handle        (handle),
    .done          (done),
    .result_slot   (result_slot),
    .result_handle (result_handle),
    .found         (found),
    .status        (status)
  );

  always #2 clk = ~clk;

  // Our own copy of the table. It is only touched by the driver, at the edge
  // where a request is taken.
  logic              slot_used [SLOT_COUNT];
  logic [31:0]       slot_value [SLOT_COUNT];
  logic [HINT_W-1:0] free_hint;
  logic [SLOT_W-1:0] last_given;

  plan_t   request_backlog[$];
  answer_t pending_answers[$];

  bit quiet_stretch;
  int idle_left;
  bit gap_served;
  int errors;
  int checked;
  int req_seen [4];
  int full_seen;
  int found_seen;

  // Works out the result word of one request and moves the table on by it.
  function automatic answer_t predict_answer(input req_t op, input logic [SLOT_W-1:0] sid,
                                             input logic [31:0] h);
    answer_t     a;
    int unsigned scan;
    a.slot   = sid;
    a.handle = '0;
    a.found  = 1'b0;
    a.status = ST_OK;
    req_seen[op]++;
    if (op == REQ_ALLOC) begin
      if (free_hint >= SLOT_COUNT) begin
        // No free slot is known: nothing moves and the id reads as zero.
        a.slot   = '0;
        a.status = ST_FULL;
      end else begin
        // The hint goes out as is, even when that slot is in use; the slot
        // is not marked, and the hint moves to the next empty slot above.
        a.slot     = free_hint[SLOT_W-1:0];
        last_given = free_hint[SLOT_W-1:0];
        scan       = free_hint + 1;
        while (scan < SLOT_COUNT && slot_used[scan]) scan++;
        free_hint = HINT_W'(scan);
        if (scan >= SLOT_COUNT) a.status = ST_FULL;
      end
    end else if (int'(sid) >= SLOT_COUNT) begin
      a.status = ST_RANGE;
    end else begin
      case (op)
        REQ_REGISTER: begin
          // An occupied slot simply gets the new handle. Registering the
          // hinted slot steps the hint up by one without looking further.
          slot_value[sid] = h;
          slot_used[sid]  = 1'b1;
          if (free_hint == HINT_W'(sid)) free_hint = HINT_W'(sid) + 1'b1;
        end
        REQ_FREE: begin
          // The hint drops to the freed slot even if it was empty already.
          if (HINT_W'(sid) < free_hint) free_hint = HINT_W'(sid);
          slot_used[sid] = 1'b0;
        end
        default: begin
          if (slot_used[sid]) begin
            a.found  = 1'b1;
            a.handle = slot_value[sid];
          end
        end
      endcase
    end
    if (a.status == ST_FULL) full_seen++;
    if (a.found) found_seen++;
    return a;
  endfunction

  // First slot in use at or after a starting point, wrapping around; -1 if
  // the table is empty.
  function automatic int occupied_near(input int from);
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (slot_used[(from + k) % SLOT_COUNT]) return (from + k) % SLOT_COUNT;
    end
    return -1;
  endfunction

  function automatic int lowest_empty();
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (!slot_used[k]) return k;
    end
    return -1;
  endfunction

  // Turns a planned pick into the request that goes out now. Returns 0 when
  // the pick has nothing to do and the word is dropped.
  function automatic bit settle_pick(input plan_t p, output req_t op,
                                     output logic [SLOT_W-1:0] sid, output logic [31:0] h);
    int hit;
    op  = p.op;
    sid = p.slot;
    h   = p.handle;
    case (p.pick)
      PICK_ALLOC:    op = REQ_ALLOC;
      PICK_REG_LAST: begin
        op  = REQ_REGISTER;
        sid = last_given;
      end
      PICK_REG_HINT: begin
        op = REQ_REGISTER;
        if (free_hint < SLOT_COUNT) sid = free_hint[SLOT_W-1:0];
      end
      PICK_REG_ANY:  op = REQ_REGISTER;
      PICK_FREE_USED, PICK_LOOK_USED: begin
        op  = (p.pick == PICK_FREE_USED) ? REQ_FREE : REQ_LOOKUP;
        hit = occupied_near(int'(p.slot));
        if (hit >= 0) sid = hit[SLOT_W-1:0];
      end
      PICK_FREE_ANY: op = REQ_FREE;
      PICK_LOOK_ANY: op = REQ_LOOKUP;
      PICK_FILL: begin
        hit = lowest_empty();
        if (hit < 0) return 1'b0;
        op  = REQ_REGISTER;
        sid = hit[SLOT_W-1:0];
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [31:0] random_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Queues one word. Every so often a stretch without idling starts or ends.
  function automatic void plan_request(input pick_t pick, input req_t op, input int slot,
                                       input logic [31:0] h);
    plan_t p;
    if ($urandom_range(0, 39) == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
    p.pick   = pick;
    p.op     = op;
    p.slot   = slot[SLOT_W-1:0];
    p.handle = h;
    p.gap    = quiet_stretch ? 0 : $urandom_range(0, 14);
    request_backlog.push_back(p);
  endfunction

  // Random traffic. Allocates are mostly followed by a register of the id
  // just handed out, as a real user would do; the rest is free, lookup and
  // stray requests aimed at random slots.
  function automatic void plan_mix(input int count);
    int n;
    int r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        plan_request(PICK_ALLOC, REQ_ALLOC, $urandom_range(0, SLOT_COUNT - 1), random_handle());
        plan_request(PICK_REG_LAST, REQ_REGISTER, 0, random_handle());
        n += 2;
      end else begin
        if (r < 40)      plan_request(PICK_ALLOC, REQ_ALLOC, 0, '0);
        else if (r < 52) plan_request(PICK_REG_HINT, REQ_REGISTER, 0, '0);
        else if (r < 60) plan_request(PICK_REG_ANY, REQ_REGISTER, 0, '0);
        else if (r < 72) plan_request(PICK_FREE_USED, REQ_FREE, 0, '0);
        else if (r < 77) plan_request(PICK_FREE_ANY, REQ_FREE, 0, '0);
        else if (r < 92) plan_request(PICK_LOOK_USED, REQ_LOOKUP, 0, '0);
        else             plan_request(PICK_LOOK_ANY, REQ_LOOKUP, 0, '0);
        // Slot and handle are redrawn here so that every pick gets random
        // content, including the fields that the block ignores.
        request_backlog[$].slot   = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        request_backlog[$].handle = random_handle();
        n++;
      end
    end
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Driver. At a taken edge the request is predicted; the next word then goes
  // out after its idle gap. With no gap, start simply stays high, so a word
  // can follow its predecessor back to back. start gets exactly one
  // nonblocking write per edge.
  always @(posedge clk) begin : drive_words
    logic              go;
    plan_t             nxt;
    req_t              op;
    logic [SLOT_W-1:0] sid;
    logic [31:0]       h;
    if (rst) begin
      start <= 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) slot_used[k] = 1'b0;
      free_hint  = '0;
      last_given = '0;
      idle_left  = 0;
      gap_served = 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        pending_answers.push_back(predict_answer(req_t'(req_type), slot_id, handle));
        go = 1'b0;
      end
      if (!go && request_backlog.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (request_backlog[0].pick == PICK_DRAIN) begin
          if (pending_answers.size() == 0) void'(request_backlog.pop_front());
        end else if (!gap_served && request_backlog[0].gap > 0) begin
          // This cycle is the first idle one of the gap.
          idle_left  = request_backlog[0].gap - 1;
          gap_served = 1'b1;
        end else begin
          nxt        = request_backlog.pop_front();
          gap_served = 1'b0;
          if (settle_pick(nxt, op, sid, h)) begin
            req_type <= op;
            slot_id  <= sid;
            handle   <= h;
            go       = 1'b1;
          end
        end
      end
      start <= go;
    end
  end

  // Monitor. A result word is on the ports for one cycle only and is taken
  // at the edge that ends that cycle.
  always @(posedge clk) begin : check_results
    answer_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_answers.size() == 0) begin
        note_error($sformatf("result word with no request outstanding: slot %0d status %0d",
                             result_slot, status));
      end else begin
        want = pending_answers.pop_front();
        checked++;
        if (result_slot !== want.slot)
          note_error($sformatf("result_slot: expected %0d, got %0d", want.slot, result_slot));
        if (result_handle !== want.handle)
          note_error($sformatf("result_handle: expected %h, got %h",
                               want.handle, result_handle));
        if (found !== want.found)
          note_error($sformatf("found: expected %0b, got %0b", want.found, found));
        if (status !== want.status)
          note_error($sformatf("status: expected %0d, got %0d", want.status, status));
      end
    end
  end

  initial begin : stimulus
    quiet_stretch = 1'b0;

    // Directed start on an empty table.
    plan_request(PICK_FIXED, REQ_LOOKUP, 0, '1);            // lookup of an empty slot
    plan_request(PICK_FIXED, REQ_FREE, 1023, '1);           // free of an empty slot
    plan_request(PICK_FIXED, REQ_ALLOC, 1023, '1);          // gets 0
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);             // gets 1, slot 0 is unmarked
    plan_request(PICK_FIXED, REQ_REGISTER, 0, 32'hFFFF_FFFF);
    plan_request(PICK_FIXED, REQ_REGISTER, 2, 32'h0000_0000); // on the hint
    plan_request(PICK_FIXED, REQ_REGISTER, 1023, 32'hA5A5_A5A5);
    plan_request(PICK_FIXED, REQ_REGISTER, 3, 32'h1234_5678);
    plan_request(PICK_FIXED, REQ_REGISTER, 3, 32'h5A5A_5A5A); // overwrite
    plan_request(PICK_FIXED, REQ_REGISTER, 5, 32'h0000_FFFF);
    plan_request(PICK_FIXED, REQ_REGISTER, 4, 32'hFFFF_0000); // hint lands on slot 5, in use
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);             // hands out the occupied slot 5
    plan_request(PICK_FIXED, REQ_LOOKUP, 0, '0);
    plan_request(PICK_FIXED, REQ_LOOKUP, 3, 32'hDEAD_BEEF);
    plan_request(PICK_FIXED, REQ_LOOKUP, 1023, '0);
    plan_request(PICK_FIXED, REQ_FREE, 1023, '0);           // hint is lower, stays put
    plan_request(PICK_FIXED, REQ_FREE, 0, 32'h8000_0001);   // hint drops to 0
    plan_request(PICK_FIXED, REQ_LOOKUP, 0, '0);
    plan_request(PICK_FIXED, REQ_LOOKUP, 1022, '0);
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);
    plan_request(PICK_FIXED, REQ_REGISTER, 1, 32'h0000_0001);
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);             // hands out slot 2, in use; hint skips 3 to 5
    plan_request(PICK_DRAIN, REQ_ALLOC, 0, '0);

    plan_mix(60);
    // Let the block run dry once before the table is filled up.
    plan_request(PICK_DRAIN, REQ_ALLOC, 0, '0);

    // Fill every slot, then probe the full table: allocate with no free slot
    // above the hint, allocate with the hint at the top, and the hint coming
    // back down after a free.
    for (int k = 0; k < SLOT_COUNT; k++) plan_request(PICK_FILL, REQ_REGISTER, 0, random_handle());
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);
    plan_request(PICK_FIXED, REQ_ALLOC, 77, '1);
    plan_request(PICK_FIXED, REQ_FREE, 1023, '0);
    plan_request(PICK_FIXED, REQ_LOOKUP, 1023, '0);
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);
    plan_request(PICK_FIXED, REQ_FREE, 512, '0);
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);
    plan_request(PICK_FIXED, REQ_ALLOC, 0, '0);
    plan_request(PICK_FIXED, REQ_LOOKUP, 512, '0);

    // More random traffic, now starting from a nearly full table.
    plan_mix(60);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge so that the driver's updates have settled.
    while (request_backlog.size() != 0 || start || pending_answers.size() != 0)
      @(negedge clk);
    // Anything arriving late is caught by the monitor as a result with no request outstanding.
    repeat (40) @(negedge clk);

    $display("Checked %0d result words from %0d allocate, %0d register, %0d free, %0d lookup.",
             checked, req_seen[REQ_ALLOC], req_seen[REQ_REGISTER], req_seen[REQ_FREE],
             req_seen[REQ_LOOKUP]);
    $display("Full-table allocates: %0d, lookup hits: %0d, mismatches: %0d.",
             full_seen, found_seen, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The timeout lies well beyond what a correct run needs.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout: the block stopped taking requests or returning results.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
sv/lfsa_pkg.sv
sv/lfsa_occ_map.sv
sv/lowest_free_slot_id_allocator.sv
sim/lowest_free_slot_id_allocator_test.sv
